// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. They expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every clock edge outside of reset.
`define FTWA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define FTWA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define FTWA_ASSERT(lbl, clk, rst, prop)
`define FTWA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/ftwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ftwa_pkg
// Types and constants shared by the flight timer modules.
// ----------------------------------------------------------------------------
package ftwa_pkg;

  // Full stick travel of the throttle mixer output (a power of two).
  localparam int STICK_TRAVEL = 512;
  // Instance number; names the timer only.
  localparam int TIMER_ID     = 0;
  localparam int PCT_SCALE    = 100;
  localparam int WARN_STEP    = 10;

  // Count range.
  localparam int CNT_W   = 17;
  localparam int CNT_MAX = 65535;
  localparam int CNT_MIN = -65536;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    TT_OFF    = 2'd0,
    TT_HIDDEN = 2'd1,
    TT_UP     = 2'd2,
    TT_DOWN   = 2'd3
  } timer_type_t;

  typedef enum logic [2:0] {
    RS_NEVER    = 3'd0,
    RS_THROTTLE = 3'd1,
    RS_HOLD     = 3'd2,
    RS_MODE     = 3'd3,
    RS_HOLD_INV = 3'd4,
    RS_MODE_INV = 3'd5
  } run_src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_TYPE = 2'd0,
    REG_RUN_SOURCE = 2'd1,
    REG_THRESHOLD  = 2'd2,
    REG_SET_TIME   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    timer_type_t        timer_type;
    run_src_t           run_source;
    logic signed [7:0]  throttle_threshold;
    logic [15:0]        set_time;
  } cfg_t;

  typedef struct packed {
    logic               restart;
    logic signed [11:0] throttle;
    logic               hold_switch;
    logic               mode_switch;
  } tick_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic                    alert;
    logic                    restart_pending;
  } state_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count_now;
    logic                    running;
    logic                    alert_on;
    logic                    prewarn;
    logic [1:0]              prewarn_index;
    logic                    timeout_beep;
  } result_t;

endpackage

// ===== hw/rtl/ftwa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ftwa_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module ftwa_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [ftwa_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [ftwa_pkg::CFG_DATA_W-1:0]     wr_data,
  output ftwa_pkg::cfg_t                      cfg
);

  // Each register takes the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_type         <= ftwa_pkg::TT_OFF;
      cfg.run_source         <= ftwa_pkg::RS_NEVER;
      cfg.throttle_threshold <= '0;
      cfg.set_time           <= '0;
    end else if (wr_en) begin
      unique case (ftwa_pkg::cfg_reg_t'(wr_index))
        ftwa_pkg::REG_TIMER_TYPE: begin
          cfg.timer_type <= ftwa_pkg::timer_type_t'(wr_data[1:0]);
        end
        ftwa_pkg::REG_RUN_SOURCE: begin
          cfg.run_source <= ftwa_pkg::run_src_t'(wr_data[2:0]);
        end
        ftwa_pkg::REG_THRESHOLD: begin
          cfg.throttle_threshold <= signed'(wr_data[7:0]);
        end
        ftwa_pkg::REG_SET_TIME: begin
          cfg.set_time <= wr_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ftwa_step.sv =====
// ----------------------------------------------------------------------------
// ftwa_step
// One tick of the timer: reload, run decision, count, alert and warnings.
// ----------------------------------------------------------------------------
module ftwa_step (
  input  ftwa_pkg::cfg_t    cfg,
  input  ftwa_pkg::tick_t   tick,
  input  ftwa_pkg::state_t  st,
  output ftwa_pkg::state_t  st_next,
  output ftwa_pkg::result_t res
);

  logic               reload;
  logic signed [17:0] set_ext;
  logic signed [17:0] cnt0;
  logic signed [19:0] prod;
  logic signed [19:0] pct;
  logic               src_hit;
  logic               run;
  logic signed [17:0] up_cnt;
  logic signed [17:0] dn_cnt;
  logic signed [17:0] cnt_run;
  logic signed [17:0] left;
  logic               alert_run;
  logic signed [17:0] cnt_new;
  logic               alert_new;
  logic [17:0]        mag_full;
  logic [16:0]        mag;
  logic [5:0]         nib_sum;
  logic               div5;
  logic               pre;
  logic [1:0]         pre_idx;

  // A restart or a pending restart reloads the count first.
  always_comb begin
    set_ext = signed'({2'b00, cfg.set_time});
    reload  = tick.restart || st.restart_pending;
    if (reload) begin
      cnt0 = (cfg.timer_type == ftwa_pkg::TT_UP) ? '0 : set_ext;
    end else begin
      cnt0 = 18'(st.count);
    end
  end

  // Throttle percent, truncated toward zero, and the run source select.
  always_comb begin
    prod = 20'(tick.throttle) * 20'(ftwa_pkg::PCT_SCALE);
    pct  = prod / 20'(ftwa_pkg::STICK_TRAVEL);
    unique case (cfg.run_source)
      ftwa_pkg::RS_THROTTLE: src_hit = pct >= 20'(cfg.throttle_threshold);
      ftwa_pkg::RS_HOLD:     src_hit = tick.hold_switch;
      ftwa_pkg::RS_MODE:     src_hit = tick.mode_switch;
      ftwa_pkg::RS_HOLD_INV: src_hit = !tick.hold_switch;
      ftwa_pkg::RS_MODE_INV: src_hit = !tick.mode_switch;
      default:               src_hit = 1'b0;
    endcase
    run = src_hit &&
          (cfg.timer_type == ftwa_pkg::TT_UP || cfg.timer_type == ftwa_pkg::TT_DOWN);
  end

  // Saturating step in the chosen direction and the alert condition.
  always_comb begin
    up_cnt = (cnt0 < 18'(ftwa_pkg::CNT_MAX)) ? cnt0 + 18'sd1 : cnt0;
    dn_cnt = (cnt0 > 18'(ftwa_pkg::CNT_MIN)) ? cnt0 - 18'sd1 : cnt0;
    if (cfg.timer_type == ftwa_pkg::TT_UP) begin
      cnt_run   = up_cnt;
      alert_run = up_cnt >= set_ext;
      left      = set_ext - up_cnt;
    end else begin
      cnt_run   = dn_cnt;
      alert_run = dn_cnt <= 18'sd0;
      left      = dn_cnt;
    end
    cnt_new   = run ? cnt_run : cnt0;
    alert_new = run ? alert_run : st.alert;
  end

  // Multiple of ten: even, and the hex digit sum is a multiple of five.
  always_comb begin
    mag_full = cnt_new[17] ? unsigned'(-cnt_new) : unsigned'(cnt_new);
    mag      = mag_full[16:0];
    nib_sum  = 6'(mag[3:0]) + 6'(mag[7:4]) + 6'(mag[11:8]) + 6'(mag[15:12]) +
               6'(mag[16]);
    div5     = 1'b0;
    for (int k = 0; k <= 12; k++) begin
      if (nib_sum == 6'(5 * k)) begin
        div5 = 1'b1;
      end
    end
  end

  // Pre-warnings at 10, 20 and 30 seconds left.
  always_comb begin
    pre     = 1'b0;
    pre_idx = 2'd0;
    if (run) begin
      if (left == 18'(ftwa_pkg::WARN_STEP)) begin
        pre = 1'b1;
      end else if (left == 18'(2 * ftwa_pkg::WARN_STEP)) begin
        pre     = 1'b1;
        pre_idx = 2'd1;
      end else if (left == 18'(3 * ftwa_pkg::WARN_STEP)) begin
        pre     = 1'b1;
        pre_idx = 2'd2;
      end
    end
  end

  // Next state and the result of this tick.
  always_comb begin
    st_next.count           = cnt_new[16:0];
    st_next.alert           = alert_new;
    st_next.restart_pending = 1'b0;
    res.count_now           = cnt_new[16:0];
    res.running             = run;
    res.alert_on            = alert_new;
    res.prewarn             = pre;
    res.prewarn_index       = pre_idx;
    res.timeout_beep        = run && alert_new && !mag[0] && div5;
  end

endmodule

// ===== hw/rtl/flight_timer_with_alerts.sv =====
// ----------------------------------------------------------------------------
// flight_timer_with_alerts
// One-second event timer with limit alert, pre-warnings and timeout beeps.
// ----------------------------------------------------------------------------
// Usage:
//   The tick channel carries one beat per second: restart, throttle and the
//   hold and mode switch levels. Each tick beat yields exactly one result beat
//   on the result channel (count, running, alert, pre-warning, timeout beep).
//   The cfg channel writes timer_type, run_source, throttle_threshold and
//   set_time by index 0 to 3; cfg_ready is always high. Write it only while
//   no tick is in flight.
//   Path: an accepted tick is registered, worked out in a single pass and
//   lands in the result register, where its result beat is valid.
//   Throughput: one tick per cycle while the receiver takes each result;
//   the single-pass step logic between the tick register and the result
//   register allows that rate.
//   Reset clears both registers, the count and the alert, and arms a reload
//   that the first tick performs. When the receiver stalls, the result is
//   held; the tick register takes one more beat only if it is empty, and
//   tick_ready drops once it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flight_timer_with_alerts (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ftwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ftwa_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Tick beats.
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic                                restart,
  input  logic signed [11:0]                  throttle,
  input  logic                                hold_switch,
  input  logic                                mode_switch,
  // Result beats.
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [ftwa_pkg::CNT_W-1:0]   count_now,
  output logic                                running,
  output logic                                alert_on,
  output logic                                prewarn,
  output logic [1:0]                          prewarn_index,
  output logic                                timeout_beep
);

  ftwa_pkg::cfg_t    cfg;
  ftwa_pkg::tick_t   tick_in;
  ftwa_pkg::tick_t   tick_q;
  logic              tick_full;
  ftwa_pkg::state_t  state;
  ftwa_pkg::state_t  state_next;
  ftwa_pkg::result_t res_next;
  ftwa_pkg::result_t result_q;
  logic              result_full;
  logic              advance;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  ftwa_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the tick register moves on when the result register is free or its beat is being taken.
  assign advance    = tick_full && (!result_full || result_ready);
  assign tick_ready = !tick_full || advance;

  assign tick_in.restart     = restart;
  assign tick_in.throttle    = throttle;
  assign tick_in.hold_switch = hold_switch;
  assign tick_in.mode_switch = mode_switch;

  // Tick input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_full <= 1'b0;
    end else if (tick_ready) begin
      tick_full <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      tick_q <= tick_in;
    end
  end

  // Single-pass step logic.
  ftwa_step u_step (
    .cfg     (cfg),
    .tick    (tick_q),
    .st      (state),
    .st_next (state_next),
    .res     (res_next)
  );

  // Timer state, updated once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.count           <= '0;
      state.alert           <= 1'b0;
      state.restart_pending <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_full <= 1'b0;
    end else if (advance) begin
      result_full <= 1'b1;
    end else if (result_ready) begin
      result_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= res_next;
    end
  end

  assign result_valid  = result_full;
  assign count_now     = result_q.count_now;
  assign running       = result_q.running;
  assign alert_on      = result_q.alert_on;
  assign prewarn       = result_q.prewarn;
  assign prewarn_index = result_q.prewarn_index;
  assign timeout_beep  = result_q.timeout_beep;

  // Checks on the timer's own logic.
  `FTWA_ASSERT(a_idle_no_flags, clk, rst,
    (result_full && !result_q.running) |-> (!result_q.prewarn && !result_q.timeout_beep))
  `FTWA_ASSERT(a_alert_holds, clk, rst,
    (advance && !res_next.running) |=> $stable(state.alert))
  `FTWA_ASSERT(a_reload_once, clk, rst,
    advance |=> !state.restart_pending)
  `FTWA_ASSERT(a_result_tracks_state, clk, rst,
    advance |=> (result_q.count_now == state.count && result_q.alert_on == state.alert))

endmodule
